// File: sv/aes_pkg.sv
`timescale 1ns / 1ps

package aes_pkg;

    // Forward substitution table.
    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Inverse substitution table.
    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Round constants, indexed by round number.
    localparam logic [7:0] RCON [0:10] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    localparam int NUM_ROUNDS = 10;

    // Configuration register indexes.
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    // Operation codes.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [127:0] block_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits in bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input block_t s, input int i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic block_t sub_bytes(input block_t s, input logic inv);
        block_t t;
        for (int i = 0; i < 16; i++)
        begin
            t[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
        end
        sub_bytes = t;
    endfunction

    function automatic block_t shift_rows(input block_t s, input logic inv);
        block_t t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (inv)
                    t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = get_byte(s, r + 4 * c);
                else
                    t[127 - 8 * (r + 4 * c) -: 8] = get_byte(s, r + 4 * ((c + r) % 4));
            end
        end
        shift_rows = t;
    endfunction

    function automatic block_t mix_columns(input block_t s, input logic inv);
        block_t t;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
            z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
            if (!inv)
            begin
                t[127 - 32 * c -: 8]  = x0 ^ x1 ^ a1 ^ a2 ^ a3;
                t[119 - 32 * c -: 8]  = a0 ^ x1 ^ x2 ^ a2 ^ a3;
                t[111 - 32 * c -: 8]  = a0 ^ a1 ^ x2 ^ x3 ^ a3;
                t[103 - 32 * c -: 8]  = x0 ^ a0 ^ a1 ^ a2 ^ x3;
            end
            else
            begin
                // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1.
                t[127 - 32 * c -: 8] = (z0 ^ y0 ^ x0) ^ (z1 ^ x1 ^ a1)
                                     ^ (z2 ^ y2 ^ a2) ^ (z3 ^ a3);
                t[119 - 32 * c -: 8] = (z0 ^ a0) ^ (z1 ^ y1 ^ x1)
                                     ^ (z2 ^ x2 ^ a2) ^ (z3 ^ y3 ^ a3);
                t[111 - 32 * c -: 8] = (z0 ^ y0 ^ a0) ^ (z1 ^ a1)
                                     ^ (z2 ^ y2 ^ x2) ^ (z3 ^ x3 ^ a3);
                t[103 - 32 * c -: 8] = (z0 ^ x0 ^ a0) ^ (z1 ^ y1 ^ a1)
                                     ^ (z2 ^ a2) ^ (z3 ^ y3 ^ x3);
            end
        end
        mix_columns = t;
    endfunction

    // Next round key from the previous one and the round constant.
    function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage

// File: sv/aes_key_sched.sv
`timescale 1ns / 1ps

// Registers the whole round key schedule after reset and once per key write, one round per
// cycle, so the cipher pipeline reads fixed round keys.
module aes_key_sched (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aes_pkg::block_t       key,
    input  logic                  load,
    output aes_pkg::block_t       round_keys [0:aes_pkg::NUM_ROUNDS]
);

    logic [3:0] step_reg;
    logic [3:0] step_next;
    aes_pkg::block_t rk_reg [1:aes_pkg::NUM_ROUNDS];

    // Expansion counter: restarts on every key write.
    always_comb
    begin
        step_next = step_reg;
        if (load)
            step_next = 4'd1;
        else if (step_reg != 4'd0 && step_reg != 4'(aes_pkg::NUM_ROUNDS))
            step_next = step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 4'd1;
        else
            step_reg <= step_next;
    end

    // Each round key is derived from the previous one, filled in order.
    always_ff @(posedge clk)
    begin
        for (int r = 1; r <= aes_pkg::NUM_ROUNDS; r++)
        begin
            if (step_reg == 4'(r))
                rk_reg[r] <= aes_pkg::next_round_key(round_keys[r - 1], aes_pkg::RCON[r]);
        end
    end

    // Round key zero follows the key registers directly.
    assign round_keys[0] = key;

    for (genvar g = 1; g <= aes_pkg::NUM_ROUNDS; g++)
    begin : g_rk
        assign round_keys[g] = rk_reg[g];
    end

endmodule

// File: sv/aes128_block_cipher.sv
`timescale 1ns / 1ps

// Channel   Signals                                  Direction
// input     start, busy, op, block_high, block_low   in (busy out)
// result    done, result_high, result_low            out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// An item passes from start to done through stage 0 and the round stages, one register each.
// A new item may start in every cycle in which busy is low; busy is high only while the round
// keys are being expanded, after reset or a key write.
// Reset clears the keys to zero and the pipeline valid bits.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module aes128_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NR = aes_pkg::NUM_ROUNDS;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [3:0]  ready_cnt_reg;
    logic [3:0]  ready_cnt_next;
    logic        cfg_wr;
    logic        accept;

    logic             vld_reg   [0:NR];
    logic             op_reg    [0:NR];
    aes_pkg::block_t  state_reg [0:NR];
    aes_pkg::block_t  round_keys [0:NR];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign accept    = start && !busy;

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ({key_high_reg, key_low_reg}),
        .load       (cfg_wr),
        .round_keys (round_keys)
    );

    // Busy until the schedule has filled the last round key.
    always_comb
    begin
        ready_cnt_next = ready_cnt_reg;
        if (cfg_wr)
            ready_cnt_next = 4'(NR);
        else if (ready_cnt_reg != 4'd0)
            ready_cnt_next = ready_cnt_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_cnt_reg <= 4'(NR);
        else
            ready_cnt_reg <= ready_cnt_next;
    end

    assign busy = (ready_cnt_reg != 4'd0);

    // Stage 0: initial key addition.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        op_reg[0] <= op;
        state_reg[0] <= {block_high, block_low}
                        ^ (op ? round_keys[NR] : round_keys[0]);
    end

    // Round stages one to ten. Decryption runs the inverse steps with the
    // key order reversed and the inverse mix applied after the key add.
    for (genvar g = 1; g <= NR; g++)
    begin : g_round
        aes_pkg::block_t enc_s, dec_s;

        always_comb
        begin
            enc_s = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_reg[g - 1], 1'b0), 1'b0);
            if (g != NR)
                enc_s = aes_pkg::mix_columns(enc_s, 1'b0);
            enc_s = enc_s ^ round_keys[g];
            dec_s = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_reg[g - 1], 1'b1), 1'b1)
                    ^ round_keys[NR - g];
            if (g != NR)
                dec_s = aes_pkg::mix_columns(dec_s, 1'b1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= vld_reg[g - 1];
        end

        always_ff @(posedge clk)
        begin
            op_reg[g]    <= op_reg[g - 1];
            state_reg[g] <= (op_reg[g - 1] == aes_pkg::OP_DECRYPT) ? dec_s : enc_s;
        end
    end

    assign done        = vld_reg[NR];
    assign result_high = state_reg[NR][127:64];
    assign result_low  = state_reg[NR][63:0];

    // No item enters while the schedule is refilling.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !vld_reg[0] || $past(!busy))
        else $error("item entered during key expansion");

    // A key write restarts expansion and raises busy.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_wr |=> busy)
        else $error("busy not raised after key write");

    // Done follows an accepted item by the pipeline depth.
    assert property (@(posedge clk) disable iff (!rst_n) accept |-> ##11 done)
        else $error("result lost in pipeline");

endmodule
